FILE: src/glmd_pkg.sv
// ----------------------------------------------------------------------------
// glmd_pkg
// Shared types and constants of the 3x3 local-maximum detector.
// ----------------------------------------------------------------------------
package glmd_pkg;

    // width of the reported row and column indexes
    localparam int IDX_WIDTH = 10;

    // configuration port
    localparam int CFG_DATA_WIDTH  = 11;
    localparam int CFG_INDEX_WIDTH = 2;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_GRID_ROWS = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_GRID_COLS = 2'd1;

    // candidate cells decided by one word, in emission order
    localparam int HIT_UP_LEFT  = 0;  // (r-1, c-1)
    localparam int HIT_UP       = 1;  // (r-1, c)
    localparam int HIT_LEFT     = 2;  // (r, c-1)
    localparam int HIT_HERE     = 3;  // (r, c)
    localparam int HIT_COUNT    = 4;

    // maxima decided by one word, handed to the result queue
    typedef struct packed {
        logic [HIT_COUNT-1:0] hits;
        logic [IDX_WIDTH-1:0] row;
        logic [IDX_WIDTH-1:0] col;
    } peak_set_t;

endpackage

FILE: src/grid_local_maximum_detector_unit.sv
// ----------------------------------------------------------------------------
// grid_local_maximum_detector_unit
// 3x3 local-maximum detection on a raster stream of grid values.
// ----------------------------------------------------------------------------
// Takes one value per cycle in raster order and reports the row and column of
// every cell strictly greater than all of its existing 8-neighbours; a cell is
// decided when its last neighbour arrives, so results of the last two rows
// come out interleaved in decision order. A result passes the s1 registers,
// the result queue and the output register. The result port sends one result
// per cycle while out_ready is high; a word deciding two or more maxima, or a
// stalled port, holds off the input, else one word per cycle. The two previous
// rows live in one line RAM (both rows per column) with a registered read.
// Writing grid_rows or grid_cols restarts the grid at row 0, column 0; a
// size of 0 acts as 1 and sizes above MAX_ROWS or MAX_COLS are clamped.
// ----------------------------------------------------------------------------
module grid_local_maximum_detector_unit #(
    parameter int MAX_COLS    = 1024,
    parameter int MAX_ROWS    = 1024,
    parameter int VALUE_WIDTH = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_write,
    input  logic [glmd_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [glmd_pkg::CFG_DATA_WIDTH-1:0]     cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [VALUE_WIDTH-1:0]           cell_value,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [glmd_pkg::IDX_WIDTH-1:0]          max_row,
    output logic [glmd_pkg::IDX_WIDTH-1:0]          max_col,
    output logic                                    last_of_run
);

    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);
    localparam int SW = glmd_pkg::CFG_DATA_WIDTH;
    localparam int IW = glmd_pkg::IDX_WIDTH;
    localparam int W  = VALUE_WIDTH;

    // grid size and position of the next cell
    logic [SW-1:0] rows_reg;
    logic [SW-1:0] cols_reg;
    logic [RW-1:0] row_cnt_reg;
    logic [CW-1:0] col_cnt_reg;
    logic          last_row;
    logic          last_col;
    logic          accept;

    // word in flight between the line RAM read and the decision
    logic                s1_valid_reg;
    logic signed [W-1:0] s1_value_reg;
    logic [CW-1:0]       s1_addr_reg;
    logic [IW-1:0]       s1_row_reg;
    logic [IW-1:0]       s1_col_reg;
    logic                s1_r1_reg;
    logic                s1_r2_reg;
    logic                s1_c1_reg;
    logic                s1_c2_reg;
    logic                s1_last_row_reg;
    logic                s1_last_col_reg;
    logic                s1_fire;

    logic [2*W-1:0]      line_rdata;
    logic signed [W-1:0] line_up;
    logic signed [W-1:0] line_lo;

    logic signed [W-1:0] win_reg  [3][3];
    logic signed [W-1:0] win_next [3][3];

    logic [2:0]                     rowok;
    logic [2:0]                     colok;
    logic [glmd_pkg::HIT_COUNT-1:0] peak;
    glmd_pkg::peak_set_t            set;
    logic                           can_load;

    function automatic logic [SW-1:0] clamp_size(input logic [SW-1:0] v, input int limit);
        logic [SW-1:0] res;
        res = v;
        if (v == '0)
        begin
            res = SW'(1);
        end
        else if (int'(v) > limit)
        begin
            res = SW'(limit);
        end
        return res;
    endfunction

    assign accept   = in_valid && in_ready;
    assign s1_fire  = s1_valid_reg && can_load;
    assign in_ready = !s1_valid_reg || s1_fire;

    assign last_row = (32'(row_cnt_reg) + 32'd1) >= 32'(rows_reg);
    assign last_col = (32'(col_cnt_reg) + 32'd1) >= 32'(cols_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg     <= SW'(1);
            cols_reg     <= SW'(1);
            row_cnt_reg  <= '0;
            col_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    glmd_pkg::REG_GRID_ROWS:
                    begin
                        rows_reg    <= clamp_size(cfg_data, MAX_ROWS);
                        row_cnt_reg <= '0;
                        col_cnt_reg <= '0;
                    end
                    glmd_pkg::REG_GRID_COLS:
                    begin
                        cols_reg    <= clamp_size(cfg_data, MAX_COLS);
                        row_cnt_reg <= '0;
                        col_cnt_reg <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (accept)
            begin
                if (last_col)
                begin
                    col_cnt_reg <= '0;
                    row_cnt_reg <= last_row ? '0 : row_cnt_reg + 1'b1;
                end
                else
                begin
                    col_cnt_reg <= col_cnt_reg + 1'b1;
                end
            end

            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_value_reg    <= cell_value;
            s1_addr_reg     <= col_cnt_reg;
            s1_row_reg      <= IW'(row_cnt_reg);
            s1_col_reg      <= IW'(col_cnt_reg);
            s1_r1_reg       <= (row_cnt_reg != '0);
            s1_r2_reg       <= (32'(row_cnt_reg) >= 32'd2);
            s1_c1_reg       <= (col_cnt_reg != '0);
            s1_c2_reg       <= (32'(col_cnt_reg) >= 32'd2);
            s1_last_row_reg <= last_row;
            s1_last_col_reg <= last_col;
        end
        if (s1_fire)
        begin
            win_reg <= win_next;
        end
    end

    // line RAM entry: previous row in the upper half, the row before in the lower
    glmd_ram #(
        .WIDTH (2 * W),
        .DEPTH (MAX_COLS)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_fire),
        .waddr (s1_addr_reg),
        .wdata ({s1_value_reg, line_lo}),
        .re    (accept),
        .raddr (col_cnt_reg),
        .rdata (line_rdata)
    );

    assign line_lo = line_rdata[2*W-1:W];
    assign line_up = line_rdata[W-1:0];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            win_next[k][0] = win_reg[k][1];
            win_next[k][1] = win_reg[k][2];
        end
        win_next[0][2] = line_up;
        win_next[1][2] = line_lo;
        win_next[2][2] = s1_value_reg;
    end

    assign rowok = {1'b1, s1_r1_reg, s1_r2_reg};
    assign colok = {1'b1, s1_c1_reg, s1_c2_reg};

    // strict 3x3 compare for the four cells that may be decided now
    always_comb
    begin
        for (int k = 0; k < glmd_pkg::HIT_COUNT; k++)
        begin
            peak[k] = 1'b1;
            for (int dr = -1; dr <= 1; dr++)
            begin
                for (int dc = -1; dc <= 1; dc++)
                begin
                    if (!(dr == 0 && dc == 0)
                        && ((k / 2) + 1 + dr) <= 2
                        && ((k % 2) + 1 + dc) <= 2)
                    begin
                        if (rowok[(k / 2) + 1 + dr] && colok[(k % 2) + 1 + dc]
                            && (win_next[(k / 2) + 1][(k % 2) + 1]
                                <= win_next[(k / 2) + 1 + dr][(k % 2) + 1 + dc]))
                        begin
                            peak[k] = 1'b0;
                        end
                    end
                end
            end
        end
    end

    always_comb
    begin
        set.hits[glmd_pkg::HIT_UP_LEFT] = s1_r1_reg && s1_c1_reg
                                          && peak[glmd_pkg::HIT_UP_LEFT];
        set.hits[glmd_pkg::HIT_UP]      = s1_r1_reg && s1_last_col_reg
                                          && peak[glmd_pkg::HIT_UP];
        set.hits[glmd_pkg::HIT_LEFT]    = s1_last_row_reg && s1_c1_reg
                                          && peak[glmd_pkg::HIT_LEFT];
        set.hits[glmd_pkg::HIT_HERE]    = s1_last_row_reg && s1_last_col_reg
                                          && peak[glmd_pkg::HIT_HERE];
        set.row = s1_row_reg;
        set.col = s1_col_reg;
    end

    glmd_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (s1_fire),
        .set         (set),
        .can_load    (can_load),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .max_row     (max_row),
        .max_col     (max_col),
        .last_of_run (last_of_run)
    );

endmodule

FILE: src/glmd_ram.sv
// ----------------------------------------------------------------------------
// glmd_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// A read of the address being written returns the new data.
// ----------------------------------------------------------------------------
module glmd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= (we && (waddr == raddr)) ? wdata : mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/glmd_emit.sv
// ----------------------------------------------------------------------------
// glmd_emit
// Result queue: holds the maxima decided by one word and sends them out
// one per cycle while out_ready is high, through a registered output.
// ----------------------------------------------------------------------------
module glmd_emit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load,
    input  glmd_pkg::peak_set_t                 set,
    output logic                                can_load,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [glmd_pkg::IDX_WIDTH-1:0]      max_row,
    output logic [glmd_pkg::IDX_WIDTH-1:0]      max_col,
    output logic                                last_of_run
);

    logic [glmd_pkg::HIT_COUNT-1:0] pend_reg;
    logic [glmd_pkg::HIT_COUNT-1:0] pend_next;
    logic [glmd_pkg::HIT_COUNT-1:0] pick;
    logic [glmd_pkg::HIT_COUNT-1:0] pend_after;
    logic [glmd_pkg::IDX_WIDTH-1:0] row_reg;
    logic [glmd_pkg::IDX_WIDTH-1:0] col_reg;
    logic                           out_valid_reg;
    logic [glmd_pkg::IDX_WIDTH-1:0] max_row_reg;
    logic [glmd_pkg::IDX_WIDTH-1:0] max_col_reg;
    logic                           last_reg;
    logic                           slot_free;
    logic                           take;

    assign slot_free  = !out_valid_reg || out_ready;
    assign take       = slot_free && (pend_reg != '0);
    // lowest pending bit goes first
    assign pick       = pend_reg & (~pend_reg + 1'b1);
    assign pend_after = take ? (pend_reg & ~pick) : pend_reg;
    assign can_load   = (pend_after == '0);
    assign pend_next  = load ? set.hits : pend_after;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            row_reg <= set.row;
            col_reg <= set.col;
        end
        if (take)
        begin
            max_row_reg <= (pick[glmd_pkg::HIT_LEFT] || pick[glmd_pkg::HIT_HERE])
                         ? row_reg : row_reg - 1'b1;
            max_col_reg <= (pick[glmd_pkg::HIT_UP] || pick[glmd_pkg::HIT_HERE])
                         ? col_reg : col_reg - 1'b1;
            last_reg    <= (pend_after == '0);
        end
    end

    assign out_valid   = out_valid_reg;
    assign max_row     = max_row_reg;
    assign max_col     = max_col_reg;
    assign last_of_run = last_reg;

endmodule

FILE: src/glmd_checker.sv
// ----------------------------------------------------------------------------
// glmd_checker
// Port-level checks of the local-maximum detector, bound to the top level.
// ----------------------------------------------------------------------------
module glmd_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_ready,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [glmd_pkg::IDX_WIDTH-1:0] max_row,
    input  logic [glmd_pkg::IDX_WIDTH-1:0] max_col,
    input  logic                           last_of_run
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(max_row) && $stable(max_col)
            && $stable(last_of_run))
        else $error("result word changed while stalled");

    // the rest of a run follows without a gap
    a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run |=> out_valid)
        else $error("gap inside a run of results");

    // empty pipeline after reset takes a word at once
    a_ready_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> in_ready)
        else $error("input not ready after reset");

endmodule

bind grid_local_maximum_detector_unit glmd_checker u_glmd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .max_row     (max_row),
    .max_col     (max_col),
    .last_of_run (last_of_run)
);

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 3x3 local-maximum detector.
// ----------------------------------------------------------------------------
// Grid words are queued by the stimulus block and sent by a bursty driver.
// Every accepted word runs through a line-buffer model of the detector here
// and its predicted peaks are queued; a monitor pops them against each
// result word taken from a receiver that stalls on its own pattern. Sizes
// are reprogrammed between phases once everything has drained.
// ----------------------------------------------------------------------------
module tb;

    localparam int MAX_COLS    = 1024;
    localparam int MAX_ROWS    = 1024;
    localparam int VALUE_WIDTH = 16;
    localparam int HALF_PERIOD = 2;
    localparam int CYCLE_LIMIT = 400000;
    localparam int CHOKE_CYCLES = 400;
    localparam int DRAIN_TAIL  = 8;
    localparam int IDX_W       = glmd_pkg::IDX_WIDTH;
    localparam int CFG_IDX_W   = glmd_pkg::CFG_INDEX_WIDTH;
    localparam int CFG_W       = glmd_pkg::CFG_DATA_WIDTH;

    typedef enum int {STY_NOISE, STY_TIES, STY_PEAKS} value_style_e;
    typedef enum int {RX_OPEN, RX_COIN, RX_SLOW} rx_mode_e;

    typedef struct {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             last;
    } peak_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]          cfg_index = '0;
    logic [CFG_W-1:0]              cfg_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic signed [VALUE_WIDTH-1:0] cell_value = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [IDX_W-1:0]              max_row;
    logic [IDX_W-1:0]              max_col;
    logic                          last_of_run;

    grid_local_maximum_detector_unit #(
        .MAX_COLS    (MAX_COLS),
        .MAX_ROWS    (MAX_ROWS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cell_value  (cell_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .max_row     (max_row),
        .max_col     (max_col),
        .last_of_run (last_of_run)
    );

    always #HALF_PERIOD clk = ~clk;

    // peak model state
    bit signed [VALUE_WIDTH-1:0] upper_line [MAX_COLS];
    bit signed [VALUE_WIDTH-1:0] lower_line [MAX_COLS];
    bit signed [VALUE_WIDTH-1:0] win [9];
    int                          rows_eff = 1;
    int                          cols_eff = 1;
    int                          row_cnt = 0;
    int                          col_cnt = 0;

    logic [VALUE_WIDTH-1:0] pending_words [$];
    peak_t                  expected_peaks [$];

    int  words_taken = 0;
    int  peaks_seen = 0;
    int  mismatches = 0;
    int  size_writes = 0;
    int  cycle_count = 0;
    bit  choke_req = 1'b0;

    // 3x3 directed grid: only the centre is a peak
    logic [VALUE_WIDTH-1:0] v_list_3x3 [9] = '{16'd1, 16'd2, 16'd3, 16'd4, 16'd9,
                                               16'd5, 16'd6, 16'd7, 16'd8};

    function automatic int eff_size(logic [CFG_W-1:0] raw, int lim);
        int v;
        v = raw;
        if (v == 0)
            v = 1;
        if (v > lim)
            v = lim;
        return v;
    endfunction

    // centre strictly above every neighbour that exists in the grid
    function automatic bit beats_neighbours(int cr, int cc, bit [2:0] rok, bit [2:0] cok);
        int nr;
        int nc;
        for (int dr = -1; dr <= 1; dr++)
        begin
            for (int dc = -1; dc <= 1; dc++)
            begin
                nr = cr + dr;
                nc = cc + dc;
                if ((dr != 0 || dc != 0) && nr >= 0 && nr <= 2 && nc >= 0 && nc <= 2)
                begin
                    if (rok[nr] && cok[nc] && win[cr*3+cc] <= win[nr*3+nc])
                        return 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    task automatic predict_peaks(input logic [VALUE_WIDTH-1:0] raw);
        int    r;
        int    c;
        bit    last_row;
        bit    last_col;
        bit [2:0] rok;
        bit [2:0] cok;
        bit signed [VALUE_WIDTH-1:0] up;
        bit signed [VALUE_WIDTH-1:0] lo;
        peak_t found [$];
        peak_t p;
        r = row_cnt;
        c = col_cnt;
        last_row = (r + 1 >= rows_eff);
        last_col = (c + 1 >= cols_eff);
        up = upper_line[c];
        lo = lower_line[c];
        upper_line[c] = lo;
        lower_line[c] = raw;
        for (int k = 0; k < 3; k++)
        begin
            win[k*3+0] = win[k*3+1];
            win[k*3+1] = win[k*3+2];
        end
        win[2] = up;
        win[5] = lo;
        win[8] = raw;
        rok = {1'b1, r >= 1, r >= 2};
        cok = {1'b1, c >= 1, c >= 2};
        p.last = 1'b0;
        if (r >= 1 && c >= 1 && beats_neighbours(1, 1, rok, cok))
        begin
            p.row = IDX_W'(r - 1);
            p.col = IDX_W'(c - 1);
            found.push_back(p);
        end
        if (r >= 1 && last_col && beats_neighbours(1, 2, rok, cok))
        begin
            p.row = IDX_W'(r - 1);
            p.col = IDX_W'(c);
            found.push_back(p);
        end
        if (last_row && c >= 1 && beats_neighbours(2, 1, rok, cok))
        begin
            p.row = IDX_W'(r);
            p.col = IDX_W'(c - 1);
            found.push_back(p);
        end
        if (last_row && last_col && beats_neighbours(2, 2, rok, cok))
        begin
            p.row = IDX_W'(r);
            p.col = IDX_W'(c);
            found.push_back(p);
        end
        if (found.size() != 0)
            found[found.size()-1].last = 1'b1;
        foreach (found[i])
            expected_peaks.push_back(found[i]);
        if (last_col)
        begin
            col_cnt = 0;
            row_cnt = last_row ? 0 : r + 1;
        end
        else
            col_cnt = c + 1;
    endtask

    // sender: bursts of words separated by random gaps
    int gap_left;
    int burst_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            cell_value <= '0;
            gap_left   <= 0;
            burst_left <= 20;
        end
        else if (!in_valid || in_ready)
        begin
            if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_words.size() != 0)
            begin
                in_valid   <= 1'b1;
                cell_value <= pending_words.pop_front();
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: its own stall pattern plus one long hold-off on request
    rx_mode_e rx_mode;
    int       mode_left;
    int       choke_left;
    bit       choke_seen;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            rx_mode    <= RX_OPEN;
            mode_left  <= 0;
            choke_left <= 0;
            choke_seen <= 1'b0;
        end
        else if (choke_req != choke_seen)
        begin
            choke_seen <= choke_req;
            choke_left <= CHOKE_CYCLES;
            out_ready  <= 1'b0;
        end
        else if (choke_left != 0)
        begin
            choke_left <= choke_left - 1;
            out_ready  <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rx_mode   <= rx_mode_e'($urandom_range(0, 2));
                mode_left <= $urandom_range(10, 80);
            end
            else
                mode_left <= mode_left - 1;
            case (rx_mode)
                RX_OPEN: out_ready <= 1'b1;
                RX_COIN: out_ready <= 1'($urandom_range(0, 1));
                default: out_ready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            predict_peaks(cell_value);
            words_taken++;
        end
    end

    always @(posedge clk)
    begin
        peak_t exp_p;
        if (rst_n && out_valid && out_ready)
        begin
            peaks_seen++;
            if (expected_peaks.size() == 0)
            begin
                $error("unexpected peak word row=%0d col=%0d", max_row, max_col);
                mismatches++;
            end
            else
            begin
                exp_p = expected_peaks.pop_front();
                if (max_row !== exp_p.row)
                begin
                    $error("max_row expected %0d got %0d", exp_p.row, max_row);
                    mismatches++;
                end
                if (max_col !== exp_p.col)
                begin
                    $error("max_col expected %0d got %0d", exp_p.col, max_col);
                    mismatches++;
                end
                if (last_of_run !== exp_p.last)
                begin
                    $error("last_of_run expected %0b got %0b", exp_p.last, last_of_run);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d peaks outstanding",
                     cycle_count, expected_peaks.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic push_word(input logic [VALUE_WIDTH-1:0] v);
        @(negedge clk);
        pending_words.push_back(v);
    endtask

    // stimulus waits until every queued word is taken and every peak is back
    task automatic drain();
        while (pending_words.size() != 0 || in_valid || expected_peaks.size() != 0)
            @(negedge clk);
        repeat (DRAIN_TAIL) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == glmd_pkg::REG_GRID_ROWS)
            rows_eff = eff_size(data, MAX_ROWS);
        else
            cols_eff = eff_size(data, MAX_COLS);
        row_cnt = 0;
        col_cnt = 0;
        size_writes++;
    endtask

    task automatic set_size(input logic [CFG_W-1:0] rows_raw,
                            input logic [CFG_W-1:0] cols_raw);
        drain();
        write_reg(glmd_pkg::REG_GRID_ROWS, rows_raw);
        write_reg(glmd_pkg::REG_GRID_COLS, cols_raw);
    endtask

    function automatic logic [VALUE_WIDTH-1:0] pick_value(value_style_e sty, int r, int c);
        case (sty)
            STY_TIES:  return VALUE_WIDTH'($urandom_range(0, 3) - 2);
            STY_PEAKS: return (r % 2 == 0 && c % 2 == 0)
                              ? VALUE_WIDTH'($urandom_range(1000, 32767))
                              : VALUE_WIDTH'($urandom_range(0, 999) - 500);
            default:
                case ($urandom_range(0, 15))
                    0:       return 16'h8000;
                    1:       return 16'h7fff;
                    default: return VALUE_WIDTH'($urandom_range(0, 65535));
                endcase
        endcase
    endfunction

    // words in raster order from the start of a fresh grid
    task automatic feed_grid(input int count, input value_style_e sty, input bit pause_mid);
        int r;
        int c;
        r = 0;
        c = 0;
        for (int i = 0; i < count; i++)
        begin
            if (pause_mid && i == count / 2)
                drain();
            push_word(pick_value(sty, r, c));
            if (c + 1 >= cols_eff)
            begin
                c = 0;
                r = (r + 1 >= rows_eff) ? 0 : r + 1;
            end
            else
                c++;
        end
    endtask

    function automatic logic [CFG_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return 11'd0;
            1:       return 11'd2047;
            2:       return CFG_W'($urandom_range(1025, 2046));
            3:       return 11'd1024;
            default: return CFG_W'($urandom_range(1, 9));
        endcase
    endfunction

    initial
    begin
        int random_words;
        int area;
        int count;

        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // sizes out of reset: every word is a lone 1x1 grid
        push_word(16'h8000);
        push_word(16'h7fff);
        push_word(16'h0000);
        set_size(11'd0, 11'd0);
        push_word(16'hffff);
        // 3x3 with the peak in the middle
        set_size(11'd3, 11'd3);
        foreach (v_list_3x3[i])
            push_word(v_list_3x3[i]);
        // ties never make a peak
        set_size(11'd2, 11'd2);
        push_word(16'd7);
        push_word(16'd7);
        push_word(16'd0);
        push_word(16'd0);
        // oversize rows, restart mid-grid by the next write
        set_size(11'd2047, 11'd2);
        push_word(16'd10);
        push_word(16'd3);
        push_word(16'd2);
        push_word(16'd1);
        set_size(11'd1, 11'd2047);
        push_word(16'd5);
        push_word(16'd1);

        // long hold-off on a peak-rich grid so the result path backs up
        set_size(11'd16, 11'd10);
        @(negedge clk);
        choke_req = ~choke_req;
        feed_grid(160, STY_PEAKS, 1'b0);
        random_words = 160;

        while (random_words < 400)
        begin
            set_size(pick_size(), pick_size());
            area = rows_eff * cols_eff;
            if (area <= 60)
                count = area * $urandom_range(1, 2)
                        + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0);
            else
                count = $urandom_range(20, 60);
            feed_grid(count, value_style_e'($urandom_range(0, 2)), $urandom_range(0, 5) == 0);
            random_words += count;
        end

        drain();
        if (expected_peaks.size() != 0)
        begin
            $error("%0d peaks never reported", expected_peaks.size());
            mismatches++;
        end
        $display("sent %0d grid words over %0d size writes, checked %0d peak words",
                 words_taken, size_writes, peaks_seen);
        $display("includes 1x1 grids, ties, clamped sizes, partial grids and a long result stall");
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
